[sv/le_pkg.sv]
// Shared types and constants for the label entropy block.
package le_pkg;

   localparam int NUM_CLASSES = 16;
   localparam int MAX_SAMPLES = 65536;
   localparam int LABEL_W     = 4;
   localparam int CNT_W       = 17;
   localparam int BIN_W       = $clog2(NUM_CLASSES + 1);
   localparam int EXP_W       = 5;
   localparam int LOG_FRAC    = 16;
   localparam int LOG_W       = EXP_W + LOG_FRAC;
   localparam int MANT_FRAC   = 30;
   localparam int MANT_W      = MANT_FRAC + 1;
   localparam int PROD_W      = CNT_W + LOG_W;
   localparam int SUM_W       = 41;
   localparam int QUOT_STEPS  = 18;
   localparam int DSH_W       = CNT_W + 4 + QUOT_STEPS;
   localparam int STEP_W      = 5;
   localparam int ENT_W       = 15;
   localparam int ENT_MAX     = 32767;
   localparam int FIFO_DEPTH  = 4;

   typedef struct packed {
      logic [LABEL_W-1:0] label;
      logic               last;
      logic               valid_sample;
   } req_type;

   typedef struct packed {
      logic [ENT_W-1:0] entropy_bits;
      logic [CNT_W-1:0] sample_count;
      logic             overflow;
   } rsp_type;

   typedef struct packed {
      logic [LABEL_W-1:0] label;
      logic               count;
      logic               last;
   } work_type;

   typedef enum logic [3:0] {
      S_RUN, S_CHECK, S_BIN, S_SQ, S_MUL, S_ACC, S_DSET, S_DIV, S_OUT
   } back_state_type;

endpackage

[sv/le_front.sv]
// Front end: classifies incoming transactions and queues the ones that matter.
module le_front
   import le_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_stall,
   input  req_type  req_data,
   output logic     work_valid,
   output work_type work_data,
   input  logic     work_pop
);

   localparam int PTR_W = $clog2(FIFO_DEPTH);

   work_type             fifo_ff [FIFO_DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]       fill_ff, fill_in;
   logic                 push;
   logic                 pop;
   logic                 keep;
   work_type             entry;

   assign req_stall  = (fill_ff == (PTR_W+1)'(FIFO_DEPTH));
   assign work_valid = (fill_ff != '0);
   assign work_data  = fifo_ff[rd_ptr_ff];

   always_comb begin
      entry.label = req_data.label;
      entry.count = req_data.valid_sample &&
                    ({1'b0, req_data.label} < (LABEL_W+1)'(NUM_CLASSES));
      entry.last  = req_data.last;
      keep        = req_data.valid_sample || req_data.last;
      push        = req_valid && !req_stall && keep;
      pop         = work_pop && work_valid;
      wr_ptr_in   = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in   = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in     = fill_ff + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[wr_ptr_ff] <= entry;
      end
   end

endmodule

[sv/le_back.sv]
// Back end: histogram counting, fixed-point log2, entropy division and result register.
module le_back
   import le_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     work_valid,
   input  work_type work_data,
   output logic     work_pop,
   output logic     rsp_valid,
   input  logic     rsp_stall,
   output rsp_type  rsp_data
);

   back_state_type          state_ff, state_in;
   logic [CNT_W-1:0]        counts_ff [NUM_CLASSES];
   logic [CNT_W-1:0]        total_ff;
   logic                    ovf_ff;
   logic [BIN_W-1:0]        bin_ff;
   logic [STEP_W-1:0]       step_ff;
   logic [CNT_W-1:0]        x_ff;
   logic [EXP_W-1:0]        exp_ff;
   logic [MANT_W-1:0]       mant_ff;
   logic [LOG_FRAC-1:0]     frac_ff;
   logic [PROD_W-1:0]       prod_ff;
   logic [SUM_W-1:0]        sum_ff;
   logic [SUM_W-1:0]        whole_ff;
   logic [SUM_W-1:0]        rem_ff;
   logic [DSH_W-1:0]        dsh_ff;
   logic [QUOT_STEPS-1:0]   quot_ff;
   logic                    rsp_valid_ff;
   rsp_type                 rsp_ff;

   logic                    at_whole;
   logic [CNT_W-1:0]        x_sel;
   logic [EXP_W-1:0]        x_exp;
   logic [47:0]             x_shift;
   logic [2*MANT_W-1:0]     sq;
   logic [MANT_W:0]         sq_top;
   logic                    slot_free;
   logic                    load_rsp;
   logic [SUM_W-1:0]        diff;
   logic [ENT_W-1:0]        ent_sat;

   assign at_whole  = (bin_ff == BIN_W'(NUM_CLASSES));
   assign x_sel     = at_whole ? total_ff : counts_ff[bin_ff[BIN_W-2:0]];
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      x_exp = '0;
      for (int i = 1; i < CNT_W; i++) begin
         if (x_sel[i]) begin
            x_exp = EXP_W'(i);
         end
      end
      x_shift = {31'd0, x_sel} << (MANT_FRAC - int'(x_exp));
      sq      = mant_ff * mant_ff;
      sq_top  = sq[2*MANT_W-1:MANT_FRAC];
      diff    = (whole_ff > sum_ff) ? whole_ff - sum_ff : '0;
      ent_sat = (quot_ff > QUOT_STEPS'(ENT_MAX)) ? ENT_W'(ENT_MAX) : quot_ff[ENT_W-1:0];
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_RUN: begin
            if (work_valid && work_data.last) begin
               state_in = S_CHECK;
            end
         end
         S_CHECK: state_in = (total_ff == '0) ? S_OUT : S_BIN;
         S_BIN: begin
            if (x_sel != '0) begin
               state_in = S_SQ;
            end else if (at_whole) begin
               state_in = S_DSET;
            end
         end
         S_SQ: begin
            if (step_ff == STEP_W'(LOG_FRAC - 1)) begin
               state_in = S_MUL;
            end
         end
         S_MUL: state_in = S_ACC;
         S_ACC: state_in = at_whole ? S_DSET : S_BIN;
         S_DSET: state_in = S_DIV;
         S_DIV: begin
            if (step_ff == STEP_W'(QUOT_STEPS - 1)) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (slot_free) begin
               state_in = S_RUN;
            end
         end
         default: state_in = S_RUN;
      endcase
   end

   always_comb begin
      work_pop = 1'b0;
      load_rsp = 1'b0;
      case (state_ff)
         S_RUN: work_pop = work_valid;
         S_OUT: load_rsp = slot_free;
         default: begin
            work_pop = 1'b0;
            load_rsp = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_RUN;
         rsp_valid_ff <= 1'b0;
         total_ff     <= '0;
         ovf_ff       <= 1'b0;
         for (int i = 0; i < NUM_CLASSES; i++) begin
            counts_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (load_rsp) begin
            total_ff <= '0;
            ovf_ff   <= 1'b0;
            for (int i = 0; i < NUM_CLASSES; i++) begin
               counts_ff[i] <= '0;
            end
         end else if (work_pop && work_data.count) begin
            if (total_ff < CNT_W'(MAX_SAMPLES)) begin
               counts_ff[work_data.label[BIN_W-2:0]] <=
                  counts_ff[work_data.label[BIN_W-2:0]] + 1'b1;
               total_ff <= total_ff + 1'b1;
            end else begin
               ovf_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         S_CHECK: begin
            bin_ff  <= '0;
            sum_ff  <= '0;
            quot_ff <= '0;
         end
         S_BIN: begin
            x_ff    <= x_sel;
            exp_ff  <= x_exp;
            mant_ff <= x_shift[MANT_W-1:0];
            frac_ff <= '0;
            step_ff <= '0;
            if (x_sel == '0) begin
               bin_ff <= bin_ff + 1'b1;
            end
         end
         S_SQ: begin
            mant_ff <= sq_top[MANT_W] ? sq_top[MANT_W:1] : sq_top[MANT_W-1:0];
            frac_ff <= {frac_ff[LOG_FRAC-2:0], sq_top[MANT_W]};
            step_ff <= step_ff + 1'b1;
         end
         S_MUL: prod_ff <= x_ff * {exp_ff, frac_ff};
         S_ACC: begin
            if (at_whole) begin
               whole_ff <= SUM_W'(prod_ff);
            end else begin
               sum_ff <= sum_ff + SUM_W'(prod_ff);
               bin_ff <= bin_ff + 1'b1;
            end
         end
         S_DSET: begin
            rem_ff  <= diff + SUM_W'({total_ff, 3'b000});
            dsh_ff  <= DSH_W'({total_ff, 4'b0000}) << (QUOT_STEPS - 1);
            quot_ff <= '0;
            step_ff <= '0;
         end
         S_DIV: begin
            if (rem_ff >= SUM_W'(dsh_ff)) begin
               rem_ff  <= rem_ff - SUM_W'(dsh_ff);
               quot_ff <= {quot_ff[QUOT_STEPS-2:0], 1'b1};
            end else begin
               quot_ff <= {quot_ff[QUOT_STEPS-2:0], 1'b0};
            end
            dsh_ff  <= dsh_ff >> 1;
            step_ff <= step_ff + 1'b1;
         end
         S_OUT: begin
            if (load_rsp) begin
               rsp_ff.entropy_bits <= ent_sat;
               rsp_ff.sample_count <= total_ff;
               rsp_ff.overflow     <= ovf_ff;
            end
         end
         default: begin
         end
      endcase
   end

endmodule

[sv/label_entropy.sv]
// Top level of the label entropy block.
//
// The req channel carries one class label per transaction with a last flag
// and a valid_sample flag. Counted labels go into a histogram of NUM_CLASSES
// bins. On the transaction marked last the block returns one rsp transaction
// with the Shannon entropy in bits (12 fraction bits), the sample count and
// an overflow flag, then clears the histogram for the next set.
// Labels are counted at one transaction per cycle, except while a set is closing
// or its result waits for the output register, through a four-entry queue
// between the front end and the back end. Closing a set runs each nonzero bin
// and then the total through the shared squaring log2 unit, then the radix-2
// divider; empty bins are skipped and an empty set goes straight to the result.
// The queue stops draining during that time.
// Reset empties the queue, clears the histogram and drops any pending result.
// While rsp_stall is high the result holds in its output register; the back
// end can keep counting the next set until that set closes.
module label_entropy
   import le_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic     work_valid;
   work_type work_data;
   logic     work_pop;

   le_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .work_valid (work_valid),
      .work_data  (work_data),
      .work_pop   (work_pop)
   );

   le_back u_back (
      .clock      (clock),
      .reset      (reset),
      .work_valid (work_valid),
      .work_data  (work_data),
      .work_pop   (work_pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule
